[hdl/mcbp_pkg.sv]
// ---------------------------------------------------------------------------
// mcbp_pkg
// shared codes and types for the multi-channel byte pipe table
// ---------------------------------------------------------------------------
package mcbp_pkg;

    // request operations
    localparam logic [2:0] OP_INIT      = 3'd0;
    localparam logic [2:0] OP_CREATE    = 3'd1;
    localparam logic [2:0] OP_WRITE     = 3'd2;
    localparam logic [2:0] OP_READ      = 3'd3;
    localparam logic [2:0] OP_CLOSE_RD  = 3'd4;
    localparam logic [2:0] OP_CLOSE_WR  = 3'd5;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD       = 3'd1;
    localparam logic [2:0] ST_BLOCK     = 3'd2;
    localparam logic [2:0] ST_EOF       = 3'd3;
    localparam logic [2:0] ST_BROKEN    = 3'd4;
    localparam logic [2:0] ST_NOFREE    = 3'd5;

    // widest pipe index the table supports
    localparam int unsigned PIPE_IDX_W = 8;

    // open-flag update from the controller to the allocator
    typedef struct packed {
        logic                  clear_all;
        logic                  open;
        logic                  close_rd;
        logic                  close_wr;
        logic [PIPE_IDX_W-1:0] idx;
    } t_flag_cmd;

endpackage

[hdl/mcbp_ram.sv]
// ---------------------------------------------------------------------------
// mcbp_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module mcbp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mcbp_alloc.sv]
// ---------------------------------------------------------------------------
// mcbp_alloc
// open flags of every pipe and the lowest-free-pipe search used by create
// ---------------------------------------------------------------------------
module mcbp_alloc #(
    parameter int unsigned NUM_PIPES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mcbp_pkg::t_flag_cmd                 i_cmd,
    output logic [NUM_PIPES-1:0]                o_reader_open,
    output logic [NUM_PIPES-1:0]                o_writer_open,
    output logic                                o_free_found,
    output logic [mcbp_pkg::PIPE_IDX_W-1:0]     o_free_idx
);

    localparam int unsigned PW = NUM_PIPES > 1 ? $clog2(NUM_PIPES) : 1;

    logic [NUM_PIPES-1:0] r_rd_open, n_rd_open;
    logic [NUM_PIPES-1:0] r_wr_open, n_wr_open;
    logic [PW-1:0]        cmd_idx;

    assign cmd_idx = i_cmd.idx[PW-1:0];

    always_comb begin
        n_rd_open = r_rd_open;
        n_wr_open = r_wr_open;
        if (i_cmd.clear_all) begin
            n_rd_open = '0;
            n_wr_open = '0;
        end else begin
            if (i_cmd.open) begin
                n_rd_open[cmd_idx] = 1'b1;
                n_wr_open[cmd_idx] = 1'b1;
            end
            if (i_cmd.close_rd) begin
                n_rd_open[cmd_idx] = 1'b0;
            end
            if (i_cmd.close_wr) begin
                n_wr_open[cmd_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_open <= '0;
            r_wr_open <= '0;
        end else begin
            r_rd_open <= n_rd_open;
            r_wr_open <= n_wr_open;
        end
    end

    // lowest pipe with both ends closed wins
    always_comb begin
        o_free_found = 1'b0;
        o_free_idx   = '0;
        for (int i = NUM_PIPES - 1; i >= 0; i--) begin
            if (!r_rd_open[i] && !r_wr_open[i]) begin
                o_free_found = 1'b1;
                o_free_idx   = mcbp_pkg::PIPE_IDX_W'(i);
            end
        end
    end

    assign o_reader_open = r_rd_open;
    assign o_writer_open = r_wr_open;

endmodule

[hdl/multi_channel_byte_pipe_table.sv]
// results: init, create, write, close and errors give one result, registered from the
// execute state; a read streams its bytes from the read state, one byte a cycle
// a new request is taken only in the idle state, not while one is still in progress; the
// byte-store read port delivers one byte per cycle and the descriptor memory read is registered
// reset: all pipes closed and system not ready; the byte store and descriptor memory are not
// cleared (create rewrites a descriptor), and results cannot be stalled by the receiver
// ---------------------------------------------------------------------------
// multi_channel_byte_pipe_table
// table of ring-buffer byte pipes with descriptors and data held in memories
// ---------------------------------------------------------------------------
module multi_channel_byte_pipe_table #(
    parameter int unsigned NUM_PIPES = 8,
    parameter int unsigned BUF_BYTES = 512,
    parameter int unsigned MAX_READ  = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_operation,
    input  logic [2:0] i_pipe_index,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_read_length,
    output logic       o_strobe,
    output logic [2:0] o_status,
    output logic [2:0] o_new_pipe,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic [6:0] o_moved_count,
    output logic       o_last
);

    localparam int unsigned PW = NUM_PIPES > 1 ? $clog2(NUM_PIPES) : 1;
    localparam int unsigned BW = $clog2(BUF_BYTES);
    localparam int unsigned FW = $clog2(BUF_BYTES + 1);
    localparam int unsigned DW = 2 * BW + FW;
    localparam int unsigned SD = NUM_PIPES * BUF_BYTES;
    localparam int unsigned AW = SD > 1 ? $clog2(SD) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [2:0]    r_op;
    logic [PW-1:0] r_idx;
    logic          r_idx_ok;
    logic [7:0]    r_data;
    logic [6:0]    r_len;
    logic          r_ready, n_ready;
    logic [BW-1:0] r_ptr, n_ptr;
    logic [BW-1:0] r_tail, n_tail;
    logic [FW-1:0] r_fill, n_fill;
    logic [6:0]    r_left, n_left;
    logic [6:0]    r_n, n_n;

    logic          r_strobe, n_strobe;
    logic [2:0]    r_status, n_status;
    logic [2:0]    r_new_pipe, n_new_pipe;
    logic          r_valid, n_valid;
    logic [6:0]    r_moved, n_moved;
    logic          r_last, n_last;

    logic [PW+2:0] in_idx_wide;
    logic [PW-1:0] in_idx;

    logic          desc_we;
    logic [PW-1:0] desc_waddr;
    logic [DW-1:0] desc_wdata;
    logic [DW-1:0] desc_rdata;
    logic [BW-1:0] d_head;
    logic [BW-1:0] d_tail;
    logic [FW-1:0] d_fill;

    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [AW-1:0] store_raddr;
    logic [7:0]    store_rdata;

    mcbp_pkg::t_flag_cmd            flag_cmd;
    logic [NUM_PIPES-1:0]           rd_open;
    logic [NUM_PIPES-1:0]           wr_open;
    logic                           free_found;
    logic [mcbp_pkg::PIPE_IDX_W-1:0] free_idx;

    logic          cur_rd_open;
    logic          cur_wr_open;
    logic [6:0]    len_sat;
    logic [6:0]    take;
    logic [BW-1:0] tail_next;
    logic [BW-1:0] ptr_next;

    assign in_idx_wide = (PW + 3)'(i_pipe_index);
    assign in_idx      = in_idx_wide[PW-1:0];

    assign d_head = desc_rdata[DW-1 -: BW];
    assign d_tail = desc_rdata[FW +: BW];
    assign d_fill = desc_rdata[FW-1:0];

    assign cur_rd_open = r_idx_ok && rd_open[r_idx];
    assign cur_wr_open = r_idx_ok && wr_open[r_idx];

    assign len_sat   = (r_len > 7'(MAX_READ)) ? 7'(MAX_READ) : r_len;
    assign take      = (32'(len_sat) > 32'(d_fill)) ? 7'(d_fill) : len_sat;
    assign tail_next = (d_tail == BW'(BUF_BYTES - 1)) ? '0 : d_tail + 1'b1;
    assign ptr_next  = (r_ptr == BW'(BUF_BYTES - 1)) ? '0 : r_ptr + 1'b1;

    assign store_waddr = AW'(32'(r_idx) * BUF_BYTES + 32'(d_tail));
    assign store_raddr = AW'(32'(r_idx) * BUF_BYTES + 32'(r_ptr));

    always_comb begin
        n_state    = r_state;
        n_ready    = r_ready;
        n_ptr      = r_ptr;
        n_tail     = r_tail;
        n_fill     = r_fill;
        n_left     = r_left;
        n_n        = r_n;
        n_strobe   = 1'b0;
        n_status   = mcbp_pkg::ST_OK;
        n_new_pipe = '0;
        n_valid    = 1'b0;
        n_moved    = '0;
        n_last     = 1'b1;
        desc_we    = 1'b0;
        desc_waddr = r_idx;
        desc_wdata = {d_head, d_tail, d_fill};
        store_we   = 1'b0;
        flag_cmd   = '0;
        flag_cmd.idx = mcbp_pkg::PIPE_IDX_W'(r_idx);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                case (r_op)
                    mcbp_pkg::OP_INIT: begin
                        flag_cmd.clear_all = 1'b1;
                        n_ready = 1'b1;
                    end
                    mcbp_pkg::OP_CREATE: begin
                        if (r_ready && free_found) begin
                            flag_cmd.open = 1'b1;
                            flag_cmd.idx  = free_idx;
                            desc_we       = 1'b1;
                            desc_waddr    = free_idx[PW-1:0];
                            desc_wdata    = '0;
                            n_new_pipe    = 3'(free_idx);
                        end else begin
                            n_status = mcbp_pkg::ST_NOFREE;
                        end
                    end
                    mcbp_pkg::OP_WRITE: begin
                        if (!cur_wr_open) begin
                            n_status = mcbp_pkg::ST_BAD;
                        end else if (!cur_rd_open) begin
                            n_status = mcbp_pkg::ST_BROKEN;
                        end else if (d_fill == FW'(BUF_BYTES)) begin
                            n_status = mcbp_pkg::ST_BLOCK;
                        end else begin
                            store_we   = 1'b1;
                            desc_we    = 1'b1;
                            desc_wdata = {d_head, tail_next, d_fill + 1'b1};
                            n_moved    = 7'd1;
                        end
                    end
                    mcbp_pkg::OP_READ: begin
                        if (!cur_rd_open) begin
                            n_status = mcbp_pkg::ST_BAD;
                        end else if (d_fill == '0) begin
                            n_status = cur_wr_open ? mcbp_pkg::ST_BLOCK : mcbp_pkg::ST_EOF;
                        end else if (take != '0) begin
                            // byte run streams from the store in the read state
                            n_strobe = 1'b0;
                            n_state  = S_READ;
                            n_ptr    = d_head;
                            n_tail   = d_tail;
                            n_fill   = d_fill - FW'(take);
                            n_left   = take;
                            n_n      = take;
                        end
                    end
                    mcbp_pkg::OP_CLOSE_RD: begin
                        if (r_idx_ok) begin
                            flag_cmd.close_rd = 1'b1;
                        end else begin
                            n_status = mcbp_pkg::ST_BAD;
                        end
                    end
                    mcbp_pkg::OP_CLOSE_WR: begin
                        if (r_idx_ok) begin
                            flag_cmd.close_wr = 1'b1;
                        end else begin
                            n_status = mcbp_pkg::ST_BAD;
                        end
                    end
                    default: begin
                        n_status = mcbp_pkg::ST_BAD;
                    end
                endcase
            end
            S_READ: begin
                // read issued now, byte leaves with the strobe next cycle
                n_strobe = 1'b1;
                n_valid  = 1'b1;
                n_ptr    = ptr_next;
                n_left   = r_left - 1'b1;
                if (r_left == 7'd1) begin
                    n_last     = 1'b1;
                    n_moved    = r_n;
                    n_state    = S_IDLE;
                    desc_we    = 1'b1;
                    desc_wdata = {ptr_next, r_tail, r_fill};
                end else begin
                    n_last = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ready  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ready  <= n_ready;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op     <= i_operation;
            r_idx    <= in_idx;
            r_idx_ok <= 32'(i_pipe_index) < NUM_PIPES;
            r_data   <= i_data_byte;
            r_len    <= i_read_length;
        end
        r_ptr      <= n_ptr;
        r_tail     <= n_tail;
        r_fill     <= n_fill;
        r_left     <= n_left;
        r_n        <= n_n;
        r_status   <= n_status;
        r_new_pipe <= n_new_pipe;
        r_valid    <= n_valid;
        r_moved    <= n_moved;
        r_last     <= n_last;
    end

    mcbp_alloc #(
        .NUM_PIPES (NUM_PIPES)
    ) u_alloc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (flag_cmd),
        .o_reader_open (rd_open),
        .o_writer_open (wr_open),
        .o_free_found  (free_found),
        .o_free_idx    (free_idx)
    );

    // descriptor: head, tail, fill of each pipe
    mcbp_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_PIPES)
    ) u_desc_ram (
        .i_clk   (i_clk),
        .i_we    (desc_we),
        .i_waddr (desc_waddr),
        .i_wdata (desc_wdata),
        .i_raddr (in_idx),
        .o_rdata (desc_rdata)
    );

    mcbp_ram #(
        .WIDTH (8),
        .DEPTH (SD)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (r_data),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    assign busy          = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_new_pipe    = r_new_pipe;
    assign o_out_byte    = r_valid ? store_rdata : 8'd0;
    assign o_byte_valid  = r_valid;
    assign o_moved_count = r_moved;
    assign o_last        = r_last;

endmodule
